/* rtl/pfba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

    localparam int ENTRY_COUNT = 1024;
    localparam int PAGE_W      = 10;
    localparam int FRAME_SHIFT = 22;
    localparam int BM_WORD_W   = 32;
    localparam int BM_BIT_W    = 5;
    localparam int DIR_MAX     = 8;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [3:0] E_PRESENT = 4'h1;
    localparam logic [3:0] E_WRITE   = 4'h2;
    localparam logic [3:0] E_USER    = 4'h4;
    localparam logic [3:0] E_BIG     = 4'h8;

    localparam logic [PAGE_W-1:0] KERNEL_LOW_PAGE  = 10'h000;
    localparam logic [PAGE_W-1:0] KERNEL_HIGH_PAGE = 10'h300;

    typedef struct packed {
        logic [PAGE_W-1:0] frame;
        logic [3:0]        flags;
    } t_dir_entry;

    localparam t_dir_entry KERNEL_ENTRY = '{frame: '0, flags: E_PRESENT | E_WRITE | E_BIG};

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        directory;
        logic [PAGE_W-1:0] virtual_page;
        logic [31:0]       amount;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [31:0] frame_addr;
        logic        tlb_invalidate;
        logic [5:0]  frames_free;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_CHK,
        ST_FREE_BM,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

/* rtl/pfba_dir_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfba_dir_ram
    import pfba_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_dir_entry    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_dir_entry         o_rdata
);

    t_dir_entry r_mem [DEPTH];
    t_dir_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/pfba_bitmap.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfba_bitmap
    import pfba_pkg::*;
#(
    parameter int WORDS = 1,
    parameter int WA    = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [WA-1:0]        i_waddr,
    input  wire logic [BM_WORD_W-1:0] i_wdata,
    input  wire logic                 i_re,
    input  wire logic [WA-1:0]        i_raddr,
    output logic      [BM_WORD_W-1:0] o_rdata,
    output logic                      o_zero_found,
    output logic      [BM_BIT_W-1:0]  o_zero_bit
);

    logic [BM_WORD_W-1:0] r_mem [WORDS];
    logic [BM_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

    // lowest clear bit of the word just read
    always_comb begin
        o_zero_found = 1'b0;
        o_zero_bit   = '0;
        for (int b = BM_WORD_W - 1; b >= 0; b--) begin
            if (!r_rdata[b]) begin
                o_zero_found = 1'b1;
                o_zero_bit   = BM_BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/pfba_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfba_seq
    import pfba_pkg::*;
#(
    parameter int FRAME_COUNT     = 32,
    parameter int DIRECTORY_COUNT = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    input  wire logic [PAGE_W-1:0] i_frame_base,
    output logic                   o_resp_valid,
    input  wire logic              i_resp_ready,
    output t_out_item              o_resp
);

    localparam int DIR_USED  = (DIRECTORY_COUNT < DIR_MAX) ? DIRECTORY_COUNT : DIR_MAX;
    localparam int MEM_DEPTH = DIR_USED * ENTRY_COUNT;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int WORDS     = (FRAME_COUNT + BM_WORD_W - 1) / BM_WORD_W;
    localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW        = $clog2(FRAME_COUNT + 1);

    t_state              r_state, n_state;
    logic [MEM_AW-1:0]   r_clr, n_clr;
    logic [CW-1:0]       r_count, n_count;
    logic [WA-1:0]       r_word, n_word;
    logic [BM_BIT_W-1:0] r_bit, n_bit;
    logic [MEM_AW-1:0]   r_dir_addr, n_dir_addr;
    logic                r_ok, n_ok;
    logic [31:0]         r_addr, n_addr;
    logic                r_tlb, n_tlb;

    logic                 dir_we, dir_re;
    logic [MEM_AW-1:0]    dir_waddr, dir_raddr;
    t_dir_entry           dir_wdata, dir_rdata;
    logic                 bm_we, bm_re;
    logic [WA-1:0]        bm_waddr, bm_raddr;
    logic [BM_WORD_W-1:0] bm_wdata, bm_rdata;
    logic                 bm_zero_found;
    logic [BM_BIT_W-1:0]  bm_zero_bit;

    logic              in_fire;
    logic              dir_in_range;
    logic [MEM_AW-1:0] in_dir_addr;
    logic [10:0]       need;
    logic [PAGE_W-1:0] alloc_idx, alloc_fnum, free_idx;
    logic              free_in_range;
    logic [PAGE_W-1:0] clr_page;

    function automatic logic [BM_WORD_W-1:0] pad_word(input logic [WA-1:0] w);
        logic [BM_WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < BM_WORD_W; b++) begin
            m[b] = (int'(w) * BM_WORD_W + b) >= FRAME_COUNT;
        end
        return m;
    endfunction

    pfba_dir_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_re    (dir_re),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    pfba_bitmap #(
        .WORDS (WORDS),
        .WA    (WA)
    ) u_bitmap (
        .i_clk        (i_clk),
        .i_we         (bm_we),
        .i_waddr      (bm_waddr),
        .i_wdata      (bm_wdata),
        .i_re         (bm_re),
        .i_raddr      (bm_raddr),
        .o_rdata      (bm_rdata),
        .o_zero_found (bm_zero_found),
        .o_zero_bit   (bm_zero_bit)
    );

    assign o_in_ready   = (r_state == ST_IDLE);
    assign in_fire      = i_in_valid && o_in_ready;
    assign dir_in_range = int'(i_in_item.directory) < DIRECTORY_COUNT;
    assign in_dir_addr  = MEM_AW'({i_in_item.directory, i_in_item.virtual_page});

    // frames needed, rounded up; 11 bits so it cannot wrap
    assign need = 11'(i_in_item.amount[31:FRAME_SHIFT]) + 11'(|i_in_item.amount[FRAME_SHIFT-1:0]);

    assign alloc_idx     = (PAGE_W'(r_word) << BM_BIT_W) | PAGE_W'(bm_zero_bit);
    assign alloc_fnum    = i_frame_base + alloc_idx;
    assign free_idx      = dir_rdata.frame - i_frame_base;
    assign free_in_range = {1'b0, free_idx} < 11'(FRAME_COUNT);
    assign clr_page      = r_clr[PAGE_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_count    = r_count;
        n_word     = r_word;
        n_bit      = r_bit;
        n_dir_addr = r_dir_addr;
        n_ok       = r_ok;
        n_addr     = r_addr;
        n_tlb      = r_tlb;
        dir_we     = 1'b0;
        dir_waddr  = r_dir_addr;
        dir_wdata  = '0;
        dir_re     = 1'b0;
        dir_raddr  = in_dir_addr;
        bm_we      = 1'b0;
        bm_waddr   = r_word;
        bm_wdata   = '0;
        bm_re      = 1'b0;
        bm_raddr   = '0;

        unique case (r_state)
            ST_CLEAR: begin
                dir_we    = 1'b1;
                dir_waddr = r_clr;
                if (clr_page == KERNEL_LOW_PAGE || clr_page == KERNEL_HIGH_PAGE) begin
                    dir_wdata = KERNEL_ENTRY;
                end
                if (r_clr < MEM_AW'(WORDS)) begin
                    bm_we    = 1'b1;
                    bm_waddr = WA'(r_clr);
                    // frame 0 starts out used, bits past the last frame stay set
                    bm_wdata = pad_word(WA'(r_clr)) | BM_WORD_W'(r_clr == '0);
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_dir_addr = in_dir_addr;
                    n_ok       = 1'b0;
                    n_addr     = '0;
                    n_tlb      = 1'b0;
                    n_word     = '0;
                    n_state    = ST_RESP;
                    unique case (i_in_item.op)
                        OP_CHECK: begin
                            n_ok = 11'(r_count) >= need;
                        end
                        OP_ALLOC: begin
                            if (dir_in_range && r_count != '0) begin
                                bm_re   = 1'b1;
                                n_state = ST_SCAN;
                            end else begin
                                n_addr = '1;
                            end
                        end
                        OP_FREE: begin
                            if (dir_in_range) begin
                                dir_re  = 1'b1;
                                n_state = ST_FREE_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (bm_zero_found) begin
                    bm_we     = 1'b1;
                    bm_wdata  = bm_rdata | (BM_WORD_W'(1) << bm_zero_bit);
                    dir_we    = 1'b1;
                    dir_wdata = '{frame: alloc_fnum, flags: E_PRESENT | E_WRITE | E_USER | E_BIG};
                    n_count   = r_count - 1'b1;
                    n_ok      = 1'b1;
                    n_addr    = {alloc_fnum, (FRAME_SHIFT)'(0)};
                    n_tlb     = 1'b1;
                    n_state   = ST_RESP;
                end else if (r_word == WA'(WORDS - 1)) begin
                    n_addr  = '1;
                    n_state = ST_RESP;
                end else begin
                    // next word of the map
                    n_word   = r_word + 1'b1;
                    bm_re    = 1'b1;
                    bm_raddr = r_word + 1'b1;
                end
            end
            ST_FREE_CHK: begin
                n_state = ST_RESP;
                if ((dir_rdata.flags & E_PRESENT) != '0) begin
                    dir_we    = 1'b1;
                    dir_wdata = '{frame: dir_rdata.frame, flags: '0};
                    n_ok      = 1'b1;
                    if (free_in_range) begin
                        n_word   = WA'(free_idx >> BM_BIT_W);
                        n_bit    = free_idx[BM_BIT_W-1:0];
                        bm_re    = 1'b1;
                        bm_raddr = WA'(free_idx >> BM_BIT_W);
                        n_state  = ST_FREE_BM;
                    end
                end
            end
            ST_FREE_BM: begin
                if (bm_rdata[r_bit]) begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata & ~(BM_WORD_W'(1) << r_bit);
                    n_count  = r_count + 1'b1;
                end
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_resp_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= CW'(FRAME_COUNT - 1);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_bit      <= n_bit;
        r_dir_addr <= n_dir_addr;
        r_ok       <= n_ok;
        r_addr     <= n_addr;
        r_tlb      <= n_tlb;
    end

    assign o_resp_valid = (r_state == ST_RESP);
    assign o_resp       = '{ok: r_ok, frame_addr: r_addr, tlb_invalidate: r_tlb,
                            frames_free: 6'(r_count)};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FRAME_COUNT))
        else $error("free count above frame count");

    a_scan_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != '0))
        else $error("bitmap scan with no free frame");

    a_alloc_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && bm_zero_found) |=> (r_count == $past(r_count) - 1'b1))
        else $error("allocate did not take one frame");

    a_tlb_on_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && o_resp.tlb_invalidate) |->
            (o_resp.ok && o_resp.frame_addr[FRAME_SHIFT-1:0] == '0))
        else $error("tlb invalidate without a frame mapping");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR || r_state == ST_SCAN) |-> !o_in_ready)
        else $error("input taken during clear or scan");

endmodule

`default_nettype wire

/* rtl/page_frame_bitmap_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// check: result passes from the RESP state into the output register; free: reads the entry in
// FREE_CHK and may clear its bitmap bit in FREE_BM, going straight to RESP when the directory
// is out of range; allocate: scans the bitmap one 32-bit word per cycle, first fit.
// one item at a time: next input taken the cycle after the result enters the output register.
// synchronous active-low reset; afterwards a clearing pass writes the directory ram and the
// frame bitmap, one entry per cycle over min(DIRECTORY_COUNT, 8) * 1024 entries, with input stalled.
module page_frame_bitmap_allocator
    import pfba_pkg::*;
#(
    parameter int FRAME_COUNT     = 32,
    parameter int DIRECTORY_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic REG_FRAME_BASE = 1'b0;

    logic [PAGE_W-1:0] r_frame_base;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic      in_ready;
    logic      resp_valid;
    logic      resp_ready;
    t_out_item resp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_BASE) ? {22'b0, r_frame_base} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_FRAME_BASE) begin
            r_frame_base <= pwdata[PAGE_W-1:0];
        end
    end

    pfba_seq #(
        .FRAME_COUNT     (FRAME_COUNT),
        .DIRECTORY_COUNT (DIRECTORY_COUNT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (in_ready),
        .i_in_item    (i_in_item),
        .i_frame_base (r_frame_base),
        .o_resp_valid (resp_valid),
        .i_resp_ready (resp_ready),
        .o_resp       (resp)
    );

    assign o_in_stall = !in_ready;

    // output register parts the sequencer from the downstream stall
    assign resp_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resp_valid && resp_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp_valid && resp_ready) begin
            r_out_item <= resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
